/* src/teba_pkg.sv */
// teba_pkg: types, codes and constants of the two-ended bump allocator.
// Shared by the channel interfaces and every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package teba_pkg;

	localparam int unsigned ADDR_W     = 21;
	localparam int unsigned SIZE_W     = 23;
	localparam int unsigned WORDS_W    = 22;
	localparam int unsigned HEAP_WORDS = 1048576;

	localparam logic [31:0] SKIP_TAG           = 32'h0000_7000;
	localparam logic [31:0] FLAG_TAGGED_ARRAY  = 32'h4000_0000;
	localparam logic [31:0] FLAG_POINTER_ARRAY = 32'h8000_0000;

	localparam logic [1:0] ACT_ALLOC_UP   = 2'd0;
	localparam logic [1:0] ACT_ALLOC_DOWN = 2'd1;
	localparam logic [1:0] ACT_LOAD       = 2'd2;

	localparam logic [1:0] KIND_TAGGED_ARRAY  = 2'd1;
	localparam logic [1:0] KIND_POINTER_ARRAY = 2'd2;

	localparam logic [2:0] RK_WRITE   = 3'd0;
	localparam logic [2:0] RK_GRANT   = 3'd1;
	localparam logic [2:0] RK_COLLECT = 3'd2;
	localparam logic [2:0] RK_EMPTY   = 3'd3;
	localparam logic [2:0] RK_LOADED  = 3'd4;

	typedef struct packed {
		logic [1:0]        action;
		logic [SIZE_W-1:0] size_bytes;
		logic [1:0]        alloc_kind;
		logic [ADDR_W-1:0] new_low_top;
		logic [ADDR_W-1:0] new_high_bottom;
	} req_t;

	typedef struct packed {
		logic [2:0]        reply_kind;
		logic [ADDR_W-1:0] word_address;
		logic [31:0]       write_value;
		logic              write_halfword;
		logic              last;
	} rsp_t;

	// up to three beats of one request plus the pointer update
	typedef struct packed {
		rsp_t [2:0]        items;
		logic [1:0]        cnt;
		logic              upd_low;
		logic              upd_high;
		logic [ADDR_W-1:0] low_top;
		logic [ADDR_W-1:0] high_bottom;
	} plan_t;

	function automatic rsp_t mk_rsp(logic [2:0] kind, logic [ADDR_W-1:0] addr,
			logic [31:0] val, logic half, logic last);
		rsp_t r;
		r.reply_kind     = kind;
		r.word_address   = addr;
		r.write_value    = val;
		r.write_halfword = half;
		r.last           = last;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] clamp_ptr(logic [ADDR_W-1:0] v);
		logic [31:0] wide;
		wide = {{(32-ADDR_W){1'b0}}, v};
		if (wide > 32'(HEAP_WORDS)) begin
			return ADDR_W'(HEAP_WORDS);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

/* src/teba_req_if.sv */
// teba_req_if: request channel (valid, ready, request payload).
// Depends on teba_pkg for req_t.
`timescale 1ns / 1ps
`default_nettype none
interface teba_req_if import teba_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/teba_rsp_if.sv */
// teba_rsp_if: result channel (valid, ready, result payload).
// Depends on teba_pkg for rsp_t.
`timescale 1ns / 1ps
`default_nettype none
interface teba_rsp_if import teba_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/teba_plan.sv */
// teba_plan: combinational decision for one request against the current pointers.
// Produces the result beats and the pointer update; depends on teba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module teba_plan import teba_pkg::*; (
	input  req_t              req,
	input  logic [ADDR_W-1:0] low_top,
	input  logic [ADDR_W-1:0] high_bottom,
	output plan_t             plan
);

	logic [SIZE_W:0]    size_rnd;
	logic [WORDS_W-1:0] words;
	logic               even;

	logic               pad_up;
	logic [WORDS_W-1:0] start_up;
	logic [WORDS_W:0]   end_up;
	logic               coll_up;

	logic               pad_dn;
	logic [ADDR_W-1:0]  top_dn;
	logic [ADDR_W-1:0]  room_dn;
	logic [WORDS_W:0]   need_dn;
	logic               coll_dn;
	logic [ADDR_W-1:0]  hdr_addr;
	logic [31:0]        flag;
	logic [31:0]        hdr_val;

	assign size_rnd = {1'b0, req.size_bytes} + (SIZE_W+1)'(3);
	assign words    = size_rnd[SIZE_W:2];
	assign even     = ~words[0];

	assign pad_up   = even & low_top[0];
	assign start_up = {1'b0, low_top} + WORDS_W'(pad_up);
	assign end_up   = {1'b0, start_up} + {1'b0, words};
	assign coll_up  = (pad_up && low_top == high_bottom)
			|| end_up > {2'b00, high_bottom};

	assign pad_dn   = even & high_bottom[0];
	assign top_dn   = high_bottom - ADDR_W'(pad_dn);
	assign room_dn  = top_dn - low_top;
	assign need_dn  = {1'b0, words} + (WORDS_W+1)'(1);
	assign coll_dn  = (pad_dn && high_bottom == low_top) || top_dn < low_top
			|| {2'b00, room_dn} < need_dn;
	assign hdr_addr = top_dn - words[ADDR_W-1:0] - ADDR_W'(1);

	always_comb begin
		case (req.alloc_kind)
			KIND_TAGGED_ARRAY:  flag = FLAG_TAGGED_ARRAY;
			KIND_POINTER_ARRAY: flag = FLAG_POINTER_ARRAY;
			default:            flag = '0;
		endcase
	end

	assign hdr_val = {{(32-WORDS_W){1'b0}}, words} | flag;

	always_comb begin
		plan             = '0;
		plan.low_top     = low_top;
		plan.high_bottom = high_bottom;
		unique case (req.action)
			ACT_ALLOC_UP: begin
				if (coll_up) begin
					plan.items[0] = mk_rsp(RK_COLLECT, '0, '0, 1'b0, 1'b1);
					plan.cnt      = 2'd1;
				end else if (pad_up) begin
					plan.items[0] = mk_rsp(RK_WRITE, low_top, SKIP_TAG, 1'b1, 1'b0);
					plan.items[1] = mk_rsp(RK_GRANT, start_up[ADDR_W-1:0], '0, 1'b0, 1'b1);
					plan.cnt      = 2'd2;
					plan.upd_low  = 1'b1;
				end else begin
					plan.items[0] = mk_rsp(RK_GRANT, start_up[ADDR_W-1:0], '0, 1'b0, 1'b1);
					plan.cnt      = 2'd1;
					plan.upd_low  = 1'b1;
				end
				plan.low_top = end_up[ADDR_W-1:0];
			end
			ACT_ALLOC_DOWN: begin
				if (req.size_bytes == '0) begin
					plan.items[0] = mk_rsp(RK_EMPTY, '0, '0, 1'b0, 1'b1);
					plan.cnt      = 2'd1;
				end else if (coll_dn) begin
					plan.items[0] = mk_rsp(RK_COLLECT, '0, '0, 1'b0, 1'b1);
					plan.cnt      = 2'd1;
				end else if (pad_dn) begin
					plan.items[0] = mk_rsp(RK_WRITE, top_dn, '0, 1'b0, 1'b0);
					plan.items[1] = mk_rsp(RK_WRITE, hdr_addr, hdr_val, 1'b0, 1'b0);
					plan.items[2] = mk_rsp(RK_GRANT, hdr_addr + ADDR_W'(1), '0, 1'b0, 1'b1);
					plan.cnt      = 2'd3;
					plan.upd_high = 1'b1;
				end else begin
					plan.items[0] = mk_rsp(RK_WRITE, hdr_addr, hdr_val, 1'b0, 1'b0);
					plan.items[1] = mk_rsp(RK_GRANT, hdr_addr + ADDR_W'(1), '0, 1'b0, 1'b1);
					plan.cnt      = 2'd2;
					plan.upd_high = 1'b1;
				end
				plan.high_bottom = hdr_addr;
			end
			ACT_LOAD: begin
				plan.items[0]    = mk_rsp(RK_LOADED, '0, '0, 1'b0, 1'b1);
				plan.cnt         = 2'd1;
				plan.upd_low     = 1'b1;
				plan.upd_high    = 1'b1;
				plan.low_top     = clamp_ptr(req.new_low_top);
				plan.high_bottom = clamp_ptr(req.new_high_bottom);
			end
			default: begin
				plan.cnt = 2'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/teba_seq.sv */
// teba_seq: result register that holds the beats of one request and drains them in order.
// Depends on teba_pkg and teba_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module teba_seq import teba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  plan_t      plan,
	output logic       free,
	teba_rsp_if.source rsp
);

	rsp_t [2:0] items_q;
	logic [1:0] cnt_q;
	logic       fire;

	assign fire      = rsp.valid & rsp.ready;
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && rsp.ready);
	assign rsp.valid = cnt_q != 2'd0;
	assign rsp.data  = items_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= plan.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= plan.items;
		end else if (fire) begin
			items_q[0] <= items_q[1];
			items_q[1] <= items_q[2];
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && fire)))
		else $error("teba_seq: plan loaded over pending beats");
	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 2'd1) |-> !items_q[0].last)
		else $error("teba_seq: last beat with more beats pending");
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> items_q[0].last)
		else $error("teba_seq: final beat not marked last");
	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cnt_q > 2'd1) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("teba_seq: beat count out of step");
`endif

endmodule
`default_nettype wire

/* src/two_ended_bump_allocator_unit.sv */
// Two-ended bump allocator: tagged objects grow up from low_top, headered objects
// grow down from high_bottom; pad, header, grant and status beats on the result channel.
//
// Use: requests arrive on req (valid/ready); each accepted request gives 1 to 3
// beats on rsp, the final one marked by last. Action 3 gives no beat.
// Path: an accepted request waits in the input register, then its beats load
// into the result register, from which the first beat can be taken.
// Throughput: one request per cycle while each gives a single beat and rsp.ready
// stays high; in general a request occupies the result register until all of its
// beats (1 to 3) are taken. The input register takes the next
// request while the previous one's beats still drain.
// Reset: both pointers clear to zero, the input and result registers empty.
// Stall: when rsp.ready is low the current beat holds; the input register fills
// and then req.ready drops until the result register frees up.
// Depends on teba_pkg, teba_req_if, teba_rsp_if, teba_plan and teba_seq.
`timescale 1ns / 1ps
`default_nettype none
module two_ended_bump_allocator_unit import teba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	teba_req_if.sink   req,
	teba_rsp_if.source rsp
);

	req_t              req_s1;
	logic              valid_s1;
	logic [ADDR_W-1:0] low_top_q;
	logic [ADDR_W-1:0] high_bottom_q;
	plan_t             plan;
	logic              free;
	logic              advance;

	assign advance   = valid_s1 & free;
	assign req.ready = ~valid_s1 | free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_top_q     <= '0;
			high_bottom_q <= '0;
		end else if (advance) begin
			if (plan.upd_low) begin
				low_top_q <= plan.low_top;
			end
			if (plan.upd_high) begin
				high_bottom_q <= plan.high_bottom;
			end
		end
	end

	teba_plan u_plan (
		.req         (req_s1),
		.low_top     (low_top_q),
		.high_bottom (high_bottom_q),
		.plan        (plan)
	);

	teba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.plan   (plan),
		.free   (free),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

/* tb/tb_two_ended_bump_allocator_unit.sv */
// Testbench for two_ended_bump_allocator_unit: directed and random allocation traffic,
// beats checked against an in-bench model of both bump pointers.
// Depends on teba_pkg, teba_req_if, teba_rsp_if and the unit itself.
`timescale 1ns / 1ps
module tb_two_ended_bump_allocator_unit;
	import teba_pkg::*;

	localparam logic [1:0]  ACT_UNUSED     = 2'd3;
	localparam logic [31:0] HDR_SIZE_MASK  = 32'h3FFF_FFFF;
	localparam int unsigned RANDOM_ITEMS   = 340;
	localparam int unsigned BURST_ITEMS    = 40;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned TIMEOUT_CYCLES = 400_000;

	logic clk;
	logic arst_n;

	teba_req_if req_ch();
	teba_rsp_if rsp_ch();

	two_ended_bump_allocator_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	logic [ADDR_W-1:0] up_ptr   = '0;
	logic [ADDR_W-1:0] down_ptr = '0;
	rsp_t              pending_beats[$];
	int unsigned       mismatches = 0;
	bit                steady     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("tb_two_ended_bump_allocator_unit: done, errors");
		$finish;
	end

	function automatic void push_beat(logic [2:0] kind, logic [ADDR_W-1:0] addr,
			logic [31:0] val, logic half, logic last);
		rsp_t b;
		b.reply_kind     = kind;
		b.word_address   = addr;
		b.write_value    = val;
		b.write_halfword = half;
		b.last           = last;
		pending_beats.push_back(b);
	endfunction

	function automatic logic [ADDR_W-1:0] sat_ptr(logic [ADDR_W-1:0] v);
		return (v > ADDR_W'(HEAP_WORDS)) ? ADDR_W'(HEAP_WORDS) : v;
	endfunction

	// pointer bookkeeping and the beats each accepted request must produce
	function automatic void predict_allocation(req_t r);
		logic [31:0] words;
		logic [31:0] start;
		logic [31:0] top;
		logic [31:0] flag;
		logic        pad;
		words = (32'(r.size_bytes) + 32'd3) >> 2;
		case (r.action)
		ACT_ALLOC_UP: begin
			pad   = ~words[0] & up_ptr[0];
			start = 32'(up_ptr) + (pad ? 32'd1 : 32'd0);
			if ((pad && up_ptr == down_ptr) || start + words > 32'(down_ptr)) begin
				push_beat(RK_COLLECT, '0, '0, 1'b0, 1'b1);
			end else begin
				if (pad) push_beat(RK_WRITE, up_ptr, SKIP_TAG, 1'b1, 1'b0);
				push_beat(RK_GRANT, ADDR_W'(start), '0, 1'b0, 1'b1);
				up_ptr = ADDR_W'(start + words);
			end
		end
		ACT_ALLOC_DOWN: begin
			pad = ~words[0] & down_ptr[0];
			top = 32'(down_ptr) - (pad ? 32'd1 : 32'd0);
			if (r.size_bytes == '0) begin
				push_beat(RK_EMPTY, '0, '0, 1'b0, 1'b1);
			end else if ((pad && down_ptr == up_ptr) || top < 32'(up_ptr) ||
					top - 32'(up_ptr) < words + 32'd1) begin
				push_beat(RK_COLLECT, '0, '0, 1'b0, 1'b1);
			end else begin
				case (r.alloc_kind)
				KIND_TAGGED_ARRAY:  flag = FLAG_TAGGED_ARRAY;
				KIND_POINTER_ARRAY: flag = FLAG_POINTER_ARRAY;
				default:            flag = '0;
				endcase
				top = top - (words + 32'd1);
				if (pad) push_beat(RK_WRITE, down_ptr - 1'b1, '0, 1'b0, 1'b0);
				push_beat(RK_WRITE, ADDR_W'(top), (words & HDR_SIZE_MASK) | flag, 1'b0, 1'b0);
				push_beat(RK_GRANT, ADDR_W'(top + 32'd1), '0, 1'b0, 1'b1);
				down_ptr = ADDR_W'(top);
			end
		end
		ACT_LOAD: begin
			up_ptr   = sat_ptr(r.new_low_top);
			down_ptr = sat_ptr(r.new_high_bottom);
			push_beat(RK_LOADED, '0, '0, 1'b0, 1'b1);
		end
		default: ;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60) return 0;
		if (sel < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60) return SIZE_W'($urandom_range(40));
		if (sel < 90) return SIZE_W'($urandom_range(400));
		if (sel < 97) return SIZE_W'($urandom_range(8191));
		return SIZE_W'($urandom);
	endfunction

	task automatic send_req(input req_t r);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_allocation(r);
	endtask

	// unused fields carry random noise
	task automatic alloc_up(input logic [SIZE_W-1:0] size);
		req_t r;
		r                 = req_t'({$urandom, $urandom});
		r.action          = ACT_ALLOC_UP;
		r.size_bytes      = size;
		send_req(r);
	endtask

	task automatic alloc_down(input logic [SIZE_W-1:0] size, input logic [1:0] kind);
		req_t r;
		r            = req_t'({$urandom, $urandom});
		r.action     = ACT_ALLOC_DOWN;
		r.size_bytes = size;
		r.alloc_kind = kind;
		send_req(r);
	endtask

	task automatic load_ptrs(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		req_t r;
		r                 = req_t'({$urandom, $urandom});
		r.action          = ACT_LOAD;
		r.new_low_top     = lo;
		r.new_high_bottom = hi;
		send_req(r);
	endtask

	task automatic send_unused();
		req_t r;
		r        = req_t'({$urandom, $urandom});
		r.action = ACT_UNUSED;
		send_req(r);
	endtask

	task automatic test_basic_alloc();
		load_ptrs(21'd1, 21'd40);
		alloc_up(23'd8);
		alloc_up(23'd5);
		alloc_up(23'd0);
		alloc_down(23'd8, 2'd0);
		alloc_down(23'd16, KIND_TAGGED_ARRAY);
		alloc_down(23'd12, KIND_POINTER_ARRAY);
		alloc_down(23'd4, 2'd3);
		alloc_down(23'd0, 2'd0);
		send_unused();
	endtask

	task automatic test_collisions();
		load_ptrs(21'd5, 21'd5);
		alloc_up(23'd8);
		alloc_down(23'd8, 2'd0);
		alloc_up(23'd0);
		load_ptrs(21'd4, 21'd6);
		alloc_down(23'd4, KIND_TAGGED_ARRAY);
		alloc_up(23'd4);
		load_ptrs(21'd100, 21'd50);
		alloc_up(23'd0);
		alloc_down(23'd4, 2'd0);
	endtask

	task automatic test_extremes();
		load_ptrs('1, '1);
		alloc_up('1);
		alloc_down('1, 2'd3);
		load_ptrs('0, ADDR_W'(HEAP_WORDS));
		alloc_up(SIZE_W'(4 * HEAP_WORDS));
		alloc_down(23'd4, KIND_POINTER_ARRAY);
	endtask

	// load a region, mostly narrow so it fills up, then allocate into it
	task automatic run_traffic(input int unsigned n_items);
		int unsigned       sent;
		int unsigned       sel;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(99);
			if (sel < 10) begin
				lo = ADDR_W'($urandom);
				hi = ADDR_W'($urandom);
			end else begin
				lo = ADDR_W'($urandom_range(HEAP_WORDS - 2100));
				if (sel < 70)      hi = lo + ADDR_W'($urandom_range(120));
				else if (sel < 95) hi = lo + ADDR_W'($urandom_range(2100));
				else               hi = lo - ADDR_W'($urandom_range(1, 50));
			end
			load_ptrs(lo, hi);
			sent++;
			repeat ($urandom_range(4, 30)) begin
				sel = $urandom_range(99);
				if (sel < 3) begin
					send_unused();
				end else begin
					if (sel < 50) alloc_up(rand_size());
					else          alloc_down(rand_size(), 2'($urandom));
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		steady = 1'b0;
		run_traffic(RANDOM_ITEMS);
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		run_traffic(BURST_ITEMS);
		steady = 1'b0;
	endtask

	// result-side backpressure
	initial begin
		int unsigned run;
		logic        level;
		run   = 0;
		level = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (steady) begin
				level = 1'b1;
			end else if (run == 0) begin
				level = ($urandom_range(99) < 70);
				if (level)                        run = $urandom_range(1, 20);
				else if ($urandom_range(9) < 8) run = $urandom_range(1, 3);
				else                              run = $urandom_range(10, 30);
			end else begin
				run--;
			end
			rsp_ch.ready <= level;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_beats.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected beat kind=%0d addr=%0d val=%h half=%b last=%b",
						$realtime, rsp_ch.data.reply_kind, rsp_ch.data.word_address,
						rsp_ch.data.write_value, rsp_ch.data.write_halfword,
						rsp_ch.data.last);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (rsp_ch.data.reply_kind !== want.reply_kind ||
						rsp_ch.data.word_address !== want.word_address ||
						rsp_ch.data.write_value !== want.write_value ||
						rsp_ch.data.write_halfword !== want.write_halfword ||
						rsp_ch.data.last !== want.last) begin
					if (mismatches < 10) begin
						$write("%0t: beat mismatch exp kind=%0d addr=%0d val=%h half=%b last=%b",
							$realtime, want.reply_kind, want.word_address,
							want.write_value, want.write_halfword, want.last);
						$display(" got kind=%0d addr=%0d val=%h half=%b last=%b",
							rsp_ch.data.reply_kind, rsp_ch.data.word_address,
							rsp_ch.data.write_value, rsp_ch.data.write_halfword,
							rsp_ch.data.last);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_alloc();
		test_collisions();
		test_extremes();
		test_random_traffic();
		test_back_to_back();

		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_two_ended_bump_allocator_unit: done, clean");
		end else begin
			$display("tb_two_ended_bump_allocator_unit: done, errors");
		end
		$finish;
	end

endmodule
